>>> rtl/qae_pkg.sv
`timescale 1ns / 1ps
package qae_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_BITS     = 31;
  localparam int DIV_PRESHIFT = 31 - FRAC_BITS;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [31:0] GRAVITY =
    32'(((64'd981 << FRAC_BITS) + 64'd50) / 64'd100);

  localparam logic [30:0] MASS_RESET  = 31'd65536;
  localparam logic [30:0] INERT_RESET = 31'd65536;
  localparam logic [30:0] ARM_RESET   = 31'd16384;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CINIT, ST_CSTEP, ST_CFIX, ST_MUL_A, ST_MUL_W,
    ST_DIV_INIT, ST_DIV_STEP, ST_DIV_END, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_CINIT, CMD_CSTEP, CMD_CFIX, CMD_MUL_A, CMD_MUL_W,
    CMD_DIV_INIT, CMD_DIV_STEP, CMD_DIV_END, CMD_OUT
  } cmd_e;

  typedef enum logic [4:0] {
    MOP_T1, MOP_T2, MOP_T3, MOP_T4, MOP_T5, MOP_T6, MOP_T7,
    MOP_PA, MOP_PB, MOP_PC, MOP_PD, MOP_PE,
    MOP_RA, MOP_RB, MOP_RC, MOP_RD, MOP_RE,
    MOP_YA, MOP_YB,
    MOP_OX, MOP_OY, MOP_OZ
  } mul_op_e;

  typedef enum logic [1:0] {DIV_Q, DIV_PITCH, DIV_ROLL, DIV_YAW} div_sel_e;

  typedef enum logic [2:0] {
    REG_MASS, REG_I1, REG_I2, REG_I3, REG_JR, REG_ARM
  } cfg_reg_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [4:0] idx;
  } ctrl_cmd_t;

  function automatic logic signed [25:0] atan_lut(input logic [3:0] i);
    logic signed [25:0] r;
    case (i)
      4'd0:    r = 26'sd2097152;
      4'd1:    r = 26'sd1238021;
      4'd2:    r = 26'sd654136;
      4'd3:    r = 26'sd332050;
      4'd4:    r = 26'sd166669;
      4'd5:    r = 26'sd83416;
      4'd6:    r = 26'sd41718;
      4'd7:    r = 26'sd20860;
      4'd8:    r = 26'sd10430;
      4'd9:    r = 26'sd5215;
      4'd10:   r = 26'sd2608;
      4'd11:   r = 26'sd1304;
      4'd12:   r = 26'sd652;
      4'd13:   r = 26'sd326;
      4'd14:   r = 26'sd163;
      4'd15:   r = 26'sd81;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/qae_ctrl.sv
`timescale 1ns / 1ps
module qae_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qae_pkg::ctrl_cmd_t  cmd_o
);

  qae_pkg::state_e   state_q, state_d;
  qae_pkg::div_sel_e dsel_q, dsel_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qae_pkg::ST_IDLE;
      dsel_q      <= qae_pkg::DIV_Q;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dsel_q      <= dsel_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    dsel_d      = dsel_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o.cmd   = qae_pkg::CMD_NONE;
    cmd_o.idx   = cnt_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      qae_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cmd = qae_pkg::CMD_LOAD;
          state_d   = qae_pkg::ST_CINIT;
        end
      end
      qae_pkg::ST_CINIT: begin
        cmd_o.cmd = qae_pkg::CMD_CINIT;
        cnt_d     = '0;
        state_d   = qae_pkg::ST_CSTEP;
      end
      qae_pkg::ST_CSTEP: begin
        cmd_o.cmd = qae_pkg::CMD_CSTEP;
        if (cnt_q == 5'(qae_pkg::CORDIC_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = qae_pkg::ST_CFIX;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      qae_pkg::ST_CFIX: begin
        cmd_o.cmd = qae_pkg::CMD_CFIX;
        cnt_d     = 5'(qae_pkg::MOP_T1);
        state_d   = qae_pkg::ST_MUL_A;
      end
      qae_pkg::ST_MUL_A: begin
        cmd_o.cmd = qae_pkg::CMD_MUL_A;
        state_d   = qae_pkg::ST_MUL_W;
      end
      qae_pkg::ST_MUL_W: begin
        cmd_o.cmd = qae_pkg::CMD_MUL_W;
        cnt_d     = cnt_q + 5'd1;
        state_d   = qae_pkg::ST_MUL_A;
        if (cnt_q == 5'(qae_pkg::MOP_YB)) begin
          dsel_d  = qae_pkg::DIV_Q;
          state_d = qae_pkg::ST_DIV_INIT;
        end else if (cnt_q == 5'(qae_pkg::MOP_OZ)) begin
          state_d = qae_pkg::ST_DONE;
        end
      end
      qae_pkg::ST_DIV_INIT: begin
        cmd_o.cmd = qae_pkg::CMD_DIV_INIT;
        cmd_o.idx = {3'b000, dsel_q};
        cnt_d     = '0;
        state_d   = qae_pkg::ST_DIV_STEP;
      end
      qae_pkg::ST_DIV_STEP: begin
        cmd_o.cmd = qae_pkg::CMD_DIV_STEP;
        if (cnt_q == 5'(qae_pkg::DIV_BITS - 1)) begin
          state_d = qae_pkg::ST_DIV_END;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      qae_pkg::ST_DIV_END: begin
        cmd_o.cmd = qae_pkg::CMD_DIV_END;
        cmd_o.idx = {3'b000, dsel_q};
        if (dsel_q == qae_pkg::DIV_YAW) begin
          cnt_d   = 5'(qae_pkg::MOP_OX);
          state_d = qae_pkg::ST_MUL_A;
        end else begin
          dsel_d  = qae_pkg::div_sel_e'(2'(dsel_q + 2'd1));
          state_d = qae_pkg::ST_DIV_INIT;
        end
      end
      qae_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.cmd   = qae_pkg::CMD_OUT;
          out_valid_d = 1'b1;
          state_d     = qae_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = qae_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != qae_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/qae_datapath.sv
`timescale 1ns / 1ps
module qae_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qae_pkg::ctrl_cmd_t  cmd_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [30:0]         cfg_data_i,
  input  logic                kind_i,
  input  logic [1:0]          rotor_i,
  input  logic signed [31:0]  thrust_i,
  input  logic signed [31:0]  spin_i,
  input  logic signed [31:0]  drag_torque_i,
  input  logic signed [15:0]  roll_angle_i,
  input  logic signed [15:0]  pitch_angle_i,
  input  logic signed [15:0]  yaw_angle_i,
  input  logic signed [31:0]  roll_rate_i,
  input  logic signed [31:0]  pitch_rate_i,
  input  logic signed [31:0]  yaw_rate_i,
  output logic signed [31:0]  accel_longitude_o,
  output logic signed [31:0]  accel_latitude_o,
  output logic signed [31:0]  accel_altitude_o,
  output logic signed [31:0]  accel_pitch_o,
  output logic signed [31:0]  accel_roll_o,
  output logic signed [31:0]  accel_yaw_o
);

  // configuration and model state
  logic [30:0]        mass_q, i1_q, i2_q, i3_q, jr_q, arm_q;
  logic signed [15:0] ang_q [3];
  logic signed [31:0] rate_q [3];
  logic signed [31:0] thr_q [4];
  logic signed [31:0] spn_q [4];
  logic signed [31:0] trq_q [4];

  // cordic lanes: roll, pitch, yaw
  logic signed [31:0] crd_x_q [3];
  logic signed [31:0] crd_y_q [3];
  logic signed [25:0] crd_z_q [3];
  logic               flip_q [3];

  // multiplier and temporaries
  logic signed [67:0] prod_q;
  logic signed [35:0] tmp_q, lin0_q, lin1_q, lin2_q, accp_q, accr_q, accy_q;
  logic signed [31:0] q_q;
  logic signed [31:0] res_q [6];
  logic signed [31:0] out_q [6];

  // divider
  logic [30:0] rem_q, dvd_q, quo_q, den_q;
  logic        dneg_q, dzero_q, dsat_q;

  logic signed [33:0] tot, tsum, wsum, d20w, d31w;
  logic signed [31:0] w_sat, d20, d31, d23, d31i, d12;

  assign tot  = 34'(thr_q[0]) + 34'(thr_q[1]) + 34'(thr_q[2]) + 34'(thr_q[3]);
  assign tsum = 34'(trq_q[0]) - 34'(trq_q[1]) + 34'(trq_q[2]) - 34'(trq_q[3]);
  assign wsum = 34'(spn_q[0]) - 34'(spn_q[1]) + 34'(spn_q[2]) - 34'(spn_q[3]);
  assign d20w = 34'(thr_q[2]) - 34'(thr_q[0]);
  assign d31w = 34'(thr_q[3]) - 34'(thr_q[1]);
  assign w_sat = qae_pkg::sat32({{34{wsum[33]}}, wsum});
  assign d20   = qae_pkg::sat32({{34{d20w[33]}}, d20w});
  assign d31   = qae_pkg::sat32({{34{d31w[33]}}, d31w});
  assign d23   = $signed({1'b0, i2_q}) - $signed({1'b0, i3_q});
  assign d31i  = $signed({1'b0, i3_q}) - $signed({1'b0, i1_q});
  assign d12   = $signed({1'b0, i1_q}) - $signed({1'b0, i2_q});

  // operand selection
  logic signed [33:0] op_a, op_b;
  logic               sh30, do_sat;
  qae_pkg::mul_op_e   mop;

  function automatic logic signed [33:0] ext34(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  assign mop = qae_pkg::mul_op_e'(cmd_i.idx);

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    sh30   = 1'b0;
    do_sat = 1'b1;
    case (mop)
      qae_pkg::MOP_T1: begin
        op_a = ext34(crd_y_q[2]); op_b = ext34(crd_y_q[0]); sh30 = 1'b1; do_sat = 1'b0;
      end
      qae_pkg::MOP_T2: begin
        op_a = ext34(crd_x_q[2]); op_b = ext34(crd_x_q[0]); sh30 = 1'b1; do_sat = 1'b0;
      end
      qae_pkg::MOP_T3, qae_pkg::MOP_T5: begin
        op_a = tmp_q[33:0]; op_b = ext34(crd_y_q[1]); sh30 = 1'b1; do_sat = 1'b0;
      end
      qae_pkg::MOP_T4: begin
        op_a = ext34(crd_y_q[2]); op_b = ext34(crd_x_q[0]); sh30 = 1'b1; do_sat = 1'b0;
      end
      qae_pkg::MOP_T6: begin
        op_a = ext34(crd_x_q[2]); op_b = ext34(crd_y_q[0]); sh30 = 1'b1; do_sat = 1'b0;
      end
      qae_pkg::MOP_T7: begin
        op_a = ext34(crd_x_q[1]); op_b = ext34(crd_x_q[0]); sh30 = 1'b1; do_sat = 1'b0;
      end
      qae_pkg::MOP_PA: begin op_a = ext34(d23);  op_b = ext34(rate_q[0]); end
      qae_pkg::MOP_PB: begin op_a = tmp_q[33:0]; op_b = ext34(rate_q[2]); end
      qae_pkg::MOP_PC: begin op_a = {3'b000, jr_q}; op_b = ext34(rate_q[0]); end
      qae_pkg::MOP_PD: begin op_a = tmp_q[33:0]; op_b = ext34(w_sat); end
      qae_pkg::MOP_PE: begin op_a = {3'b000, arm_q}; op_b = ext34(d20); end
      qae_pkg::MOP_RA: begin op_a = ext34(d31i); op_b = ext34(rate_q[1]); end
      qae_pkg::MOP_RB: begin op_a = tmp_q[33:0]; op_b = ext34(rate_q[2]); end
      qae_pkg::MOP_RC: begin op_a = {3'b000, jr_q}; op_b = ext34(rate_q[1]); end
      qae_pkg::MOP_RD: begin op_a = tmp_q[33:0]; op_b = ext34(w_sat); end
      qae_pkg::MOP_RE: begin op_a = {3'b000, arm_q}; op_b = ext34(d31); end
      qae_pkg::MOP_YA: begin op_a = ext34(d12);  op_b = ext34(rate_q[1]); end
      qae_pkg::MOP_YB: begin op_a = tmp_q[33:0]; op_b = ext34(rate_q[0]); end
      qae_pkg::MOP_OX: begin op_a = ext34(q_q); op_b = lin0_q[33:0]; sh30 = 1'b1; end
      qae_pkg::MOP_OY: begin op_a = ext34(q_q); op_b = lin1_q[33:0]; sh30 = 1'b1; end
      qae_pkg::MOP_OZ: begin
        op_a = ext34(q_q); op_b = lin2_q[33:0]; sh30 = 1'b1; do_sat = 1'b0;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // rounding, shift and saturation of the registered product
  logic signed [67:0] rnd;
  logic signed [31:0] rsat;
  logic signed [35:0] mres;
  logic signed [36:0] zdiff;

  always_comb begin
    if (sh30) begin
      rnd = (prod_q + (68'sd1 <<< 29)) >>> 30;
    end else begin
      rnd = (prod_q + (68'sd1 <<< (qae_pkg::FRAC_BITS - 1))) >>> qae_pkg::FRAC_BITS;
    end
    rsat = qae_pkg::sat32(rnd);
    if (do_sat) begin
      mres = {{4{rsat[31]}}, rsat};
    end else begin
      mres = rnd[35:0];
    end
    zdiff = {mres[35], mres} - 37'(qae_pkg::GRAVITY);
  end

  // divider front end
  logic signed [35:0] dnum;
  logic [30:0]        dden;
  logic [35:0]        dmag;
  logic [31:0]        rem2;
  logic               dbit;
  logic signed [31:0] dres;

  always_comb begin
    case (qae_pkg::div_sel_e'(cmd_i.idx[1:0]))
      qae_pkg::DIV_Q:     begin dnum = 36'(tot); dden = mass_q; end
      qae_pkg::DIV_PITCH: begin dnum = accp_q;   dden = i1_q;   end
      qae_pkg::DIV_ROLL:  begin dnum = accr_q;   dden = i2_q;   end
      qae_pkg::DIV_YAW:   begin dnum = accy_q;   dden = i3_q;   end
      default:            begin dnum = accy_q;   dden = i3_q;   end
    endcase
    dmag = dnum[35] ? 36'(-dnum) : 36'(dnum);
    rem2 = {rem_q, dvd_q[30]};
    dbit = (rem2 >= {1'b0, den_q});
    if (dzero_q) begin
      dres = '0;
    end else if (dsat_q) begin
      dres = dneg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (dneg_q) begin
      dres = -$signed({1'b0, quo_q});
    end else begin
      dres = $signed({1'b0, quo_q});
    end
  end

  // cordic lanes
  logic signed [15:0] lane_ang [3];
  assign lane_ang[0] = ang_q[0];
  assign lane_ang[1] = ang_q[1];
  assign lane_ang[2] = ang_q[2];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [16:0] a17, a_adj;
    logic               a_flip;
    logic signed [31:0] dx, dy;
    logic signed [25:0] at;

    always_comb begin
      a17 = {lane_ang[l][15], lane_ang[l]};
      if (a17 > 17'sd16384) begin
        a_adj  = a17 - 17'sd32768;
        a_flip = 1'b1;
      end else if (a17 < -17'sd16384) begin
        a_adj  = a17 + 17'sd32768;
        a_flip = 1'b1;
      end else begin
        a_adj  = a17;
        a_flip = 1'b0;
      end
      dx = crd_y_q[l] >>> cmd_i.idx[3:0];
      dy = crd_x_q[l] >>> cmd_i.idx[3:0];
      at = qae_pkg::atan_lut(cmd_i.idx[3:0]);
    end

    always_ff @(posedge clk_i) begin
      case (cmd_i.cmd)
        qae_pkg::CMD_CINIT: begin
          crd_x_q[l] <= qae_pkg::CORDIC_GAIN;
          crd_y_q[l] <= '0;
          crd_z_q[l] <= {a_adj[16], a_adj, 8'b0};
          flip_q[l]  <= a_flip;
        end
        qae_pkg::CMD_CSTEP: begin
          if (!crd_z_q[l][25]) begin
            crd_x_q[l] <= crd_x_q[l] - dx;
            crd_y_q[l] <= crd_y_q[l] + dy;
            crd_z_q[l] <= crd_z_q[l] - at;
          end else begin
            crd_x_q[l] <= crd_x_q[l] + dx;
            crd_y_q[l] <= crd_y_q[l] - dy;
            crd_z_q[l] <= crd_z_q[l] + at;
          end
        end
        qae_pkg::CMD_CFIX: begin
          if (flip_q[l]) begin
            crd_x_q[l] <= -crd_x_q[l];
            crd_y_q[l] <= -crd_y_q[l];
          end
        end
        default: begin
          crd_x_q[l] <= crd_x_q[l];
        end
      endcase
    end
  end

  // configuration and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= qae_pkg::MASS_RESET;
      i1_q   <= qae_pkg::INERT_RESET;
      i2_q   <= qae_pkg::INERT_RESET;
      i3_q   <= qae_pkg::INERT_RESET;
      jr_q   <= '0;
      arm_q  <= qae_pkg::ARM_RESET;
      for (int k = 0; k < 3; k++) begin
        ang_q[k]  <= '0;
        rate_q[k] <= '0;
      end
      for (int k = 0; k < 4; k++) begin
        thr_q[k] <= '0;
        spn_q[k] <= '0;
        trq_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          qae_pkg::REG_MASS: mass_q <= cfg_data_i;
          qae_pkg::REG_I1:   i1_q   <= cfg_data_i;
          qae_pkg::REG_I2:   i2_q   <= cfg_data_i;
          qae_pkg::REG_I3:   i3_q   <= cfg_data_i;
          qae_pkg::REG_JR:   jr_q   <= cfg_data_i;
          qae_pkg::REG_ARM:  arm_q  <= cfg_data_i;
          default: begin
            mass_q <= mass_q;
          end
        endcase
      end
      if (cmd_i.cmd == qae_pkg::CMD_LOAD) begin
        if (!kind_i) begin
          ang_q[0]  <= roll_angle_i;
          ang_q[1]  <= pitch_angle_i;
          ang_q[2]  <= yaw_angle_i;
          rate_q[0] <= roll_rate_i;
          rate_q[1] <= pitch_rate_i;
          rate_q[2] <= yaw_rate_i;
        end else begin
          thr_q[rotor_i] <= thrust_i;
          spn_q[rotor_i] <= spin_i;
          trq_q[rotor_i] <= drag_torque_i;
        end
      end
    end
  end

  // multiply, divide and result registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.cmd)
      qae_pkg::CMD_MUL_A: begin
        prod_q <= 68'(op_a) * 68'(op_b);
      end
      qae_pkg::CMD_MUL_W: begin
        case (mop)
          qae_pkg::MOP_T1: lin0_q <= mres;
          qae_pkg::MOP_T3: lin0_q <= lin0_q + mres;
          qae_pkg::MOP_T5: lin1_q <= mres;
          qae_pkg::MOP_T6: lin1_q <= lin1_q - mres;
          qae_pkg::MOP_T7: lin2_q <= mres;
          qae_pkg::MOP_PB: accp_q <= mres;
          qae_pkg::MOP_PD: accp_q <= accp_q - mres;
          qae_pkg::MOP_PE: accp_q <= accp_q + mres;
          qae_pkg::MOP_RB: accr_q <= mres;
          qae_pkg::MOP_RD: accr_q <= accr_q - mres;
          qae_pkg::MOP_RE: accr_q <= accr_q + mres;
          qae_pkg::MOP_YB: accy_q <= mres + 36'(tsum);
          qae_pkg::MOP_OX: res_q[0] <= mres[31:0];
          qae_pkg::MOP_OY: res_q[1] <= mres[31:0];
          qae_pkg::MOP_OZ: res_q[2] <= qae_pkg::sat32(68'(zdiff));
          default: tmp_q <= mres;
        endcase
      end
      qae_pkg::CMD_DIV_INIT: begin
        dneg_q  <= dnum[35];
        dzero_q <= (dnum == '0);
        dsat_q  <= ({24'b0, dmag} >= ({29'b0, dden} << qae_pkg::DIV_PRESHIFT));
        rem_q   <= 31'(dmag >> qae_pkg::DIV_PRESHIFT);
        dvd_q   <= 31'(dmag << qae_pkg::FRAC_BITS);
        den_q   <= dden;
        quo_q   <= '0;
      end
      qae_pkg::CMD_DIV_STEP: begin
        rem_q <= dbit ? 31'(rem2 - {1'b0, den_q}) : rem2[30:0];
        dvd_q <= {dvd_q[29:0], 1'b0};
        quo_q <= {quo_q[29:0], dbit};
      end
      qae_pkg::CMD_DIV_END: begin
        case (qae_pkg::div_sel_e'(cmd_i.idx[1:0]))
          qae_pkg::DIV_Q:     q_q      <= dres;
          qae_pkg::DIV_PITCH: res_q[3] <= dres;
          qae_pkg::DIV_ROLL:  res_q[4] <= dres;
          default:            res_q[5] <= dres;
        endcase
      end
      qae_pkg::CMD_OUT: begin
        for (int k = 0; k < 6; k++) begin
          out_q[k] <= res_q[k];
        end
      end
      default: begin
        prod_q <= prod_q;
      end
    endcase
  end

  assign accel_longitude_o = out_q[0];
  assign accel_latitude_o  = out_q[1];
  assign accel_altitude_o  = out_q[2];
  assign accel_pitch_o     = out_q[3];
  assign accel_roll_o      = out_q[4];
  assign accel_yaw_o       = out_q[5];

endmodule

>>> rtl/quadrotor_accel_evaluator_unit.sv
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o    kind, rotor, rotor values, attitude
// out       output     out_valid_o / out_stall_i  six accelerations
// cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// the input stays stalled from acceptance until the beat is finished: 16 shared
// cordic steps for all three angles, 22 multiplies on the single multiplier, and
// four 31-bit restoring divisions
// the result register holds a finished beat while the next one is worked on
// reset clears the attitude and rotor state and loads the register defaults
`timescale 1ns / 1ps
module quadrotor_accel_evaluator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [1:0]         rotor_i,
  input  logic signed [31:0] thrust_i,
  input  logic signed [31:0] spin_i,
  input  logic signed [31:0] drag_torque_i,
  input  logic signed [15:0] roll_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] yaw_angle_i,
  input  logic signed [31:0] roll_rate_i,
  input  logic signed [31:0] pitch_rate_i,
  input  logic signed [31:0] yaw_rate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] accel_longitude_o,
  output logic signed [31:0] accel_latitude_o,
  output logic signed [31:0] accel_altitude_o,
  output logic signed [31:0] accel_pitch_o,
  output logic signed [31:0] accel_roll_o,
  output logic signed [31:0] accel_yaw_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i
);

  qae_pkg::ctrl_cmd_t cmd;

  qae_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  qae_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .kind_i            (kind_i),
    .rotor_i           (rotor_i),
    .thrust_i          (thrust_i),
    .spin_i            (spin_i),
    .drag_torque_i     (drag_torque_i),
    .roll_angle_i      (roll_angle_i),
    .pitch_angle_i     (pitch_angle_i),
    .yaw_angle_i       (yaw_angle_i),
    .roll_rate_i       (roll_rate_i),
    .pitch_rate_i      (pitch_rate_i),
    .yaw_rate_i        (yaw_rate_i),
    .accel_longitude_o (accel_longitude_o),
    .accel_latitude_o  (accel_latitude_o),
    .accel_altitude_o  (accel_altitude_o),
    .accel_pitch_o     (accel_pitch_o),
    .accel_roll_o      (accel_roll_o),
    .accel_yaw_o       (accel_yaw_o)
  );

endmodule

>>> rtl/qae_checker.sv
`timescale 1ns / 1ps
module qae_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] accel_longitude_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a beat keeps the input stalled while it is computed
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o ##1 in_stall_o)
    else $error("input taken again too early");

  // no result appears right after an input beat
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result produced without computation");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(accel_longitude_o))
    else $error("output payload changed under stall");

endmodule

bind quadrotor_accel_evaluator_unit qae_checker u_qae_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    bit              kind;
    bit [1:0]        rotor;
    int              thrust, spin, torque;
    shortint         roll_ang, pitch_ang, yaw_ang;
    int              roll_rt, pitch_rt, yaw_rt;
  } beat_t;

  typedef struct {
    int acc [6];
  } accel_t;

  class accel_board;
    accel_t  pending_accels[$];
    longint  regs [6];
    int      angles [3];
    longint  rates [3];
    longint  thr [4], spn [4], trq [4];
    int      errors;
    int      checked;
    int      atan_steps [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                                 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    string   names [6] = '{"longitude", "latitude", "altitude", "pitch", "roll", "yaw"};

    function new();
      regs = '{qae_pkg::MASS_RESET, qae_pkg::INERT_RESET, qae_pkg::INERT_RESET,
               qae_pkg::INERT_RESET, 0, qae_pkg::ARM_RESET};
      foreach (angles[i]) begin
        angles[i] = 0;
        rates[i] = 0;
      end
      foreach (thr[i]) begin
        thr[i] = 0;
        spn[i] = 0;
        trq[i] = 0;
      end
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(int idx, longint val);
      if (idx < 6) regs[idx] = val & 64'h7FFF_FFFF;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint fx_mul(longint a, longint b);
      return sat((a * b + (64'sd1 <<< (qae_pkg::FRAC_BITS - 1))) >>> qae_pkg::FRAC_BITS);
    endfunction

    function longint q30_mul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function longint fx_div(longint num, longint den);
      if (den == 0) return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
      return sat((num * (64'sd1 <<< qae_pkg::FRAC_BITS)) / den);
    endfunction

    function void sin_cos(int ang, output longint s, output longint c);
      longint x, y, z, dx, dy;
      bit flip;
      x = qae_pkg::CORDIC_GAIN;
      y = 0;
      flip = 0;
      if (ang > 16384) begin
        ang -= 32768;
        flip = 1;
      end else if (ang < -16384) begin
        ang += 32768;
        flip = 1;
      end
      z = longint'(ang) * 256;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= atan_steps[i];
        end else begin
          x += dx;
          y -= dy;
          z += atan_steps[i];
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      s = y;
      c = x;
    endfunction

    function void note_beat(beat_t b);
      longint sr, cr, sp, cp, sy, cy, tot, q, w, acc;
      accel_t e;
      if (!b.kind) begin
        angles = '{b.roll_ang, b.pitch_ang, b.yaw_ang};
        rates = '{b.roll_rt, b.pitch_rt, b.yaw_rt};
      end else begin
        thr[b.rotor] = b.thrust;
        spn[b.rotor] = b.spin;
        trq[b.rotor] = b.torque;
      end
      sin_cos(angles[0], sr, cr);
      sin_cos(angles[1], sp, cp);
      sin_cos(angles[2], sy, cy);
      tot = thr[0] + thr[1] + thr[2] + thr[3];
      q = fx_div(tot, regs[qae_pkg::REG_MASS]);
      e.acc[0] = int'(sat(q30_mul(q, q30_mul(sy, sr) + q30_mul(q30_mul(cy, cr), sp))));
      e.acc[1] = int'(sat(q30_mul(q, q30_mul(q30_mul(sy, cr), sp) - q30_mul(cy, sr))));
      e.acc[2] = int'(sat(q30_mul(q, q30_mul(cp, cr)) - qae_pkg::GRAVITY));
      w = sat(spn[0] - spn[1] + spn[2] - spn[3]);
      acc = fx_mul(fx_mul(regs[qae_pkg::REG_I2] - regs[qae_pkg::REG_I3], rates[0]), rates[2])
          - fx_mul(fx_mul(regs[qae_pkg::REG_JR], rates[0]), w)
          + fx_mul(regs[qae_pkg::REG_ARM], sat(thr[2] - thr[0]));
      e.acc[3] = int'(fx_div(acc, regs[qae_pkg::REG_I1]));
      acc = fx_mul(fx_mul(regs[qae_pkg::REG_I3] - regs[qae_pkg::REG_I1], rates[1]), rates[2])
          - fx_mul(fx_mul(regs[qae_pkg::REG_JR], rates[1]), w)
          + fx_mul(regs[qae_pkg::REG_ARM], sat(thr[3] - thr[1]));
      e.acc[4] = int'(fx_div(acc, regs[qae_pkg::REG_I2]));
      acc = fx_mul(fx_mul(regs[qae_pkg::REG_I1] - regs[qae_pkg::REG_I2], rates[1]), rates[0])
          + (trq[0] - trq[1] + trq[2] - trq[3]);
      e.acc[5] = int'(fx_div(acc, regs[qae_pkg::REG_I3]));
      pending_accels.push_back(e);
    endfunction

    function void check_result(accel_t got);
      accel_t e;
      checked++;
      if (pending_accels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat at %0t", $realtime);
        return;
      end
      e = pending_accels.pop_front();
      for (int i = 0; i < 6; i++) begin
        if (e.acc[i] != got.acc[i]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch %s: expected %0d got %0d", names[i], e.acc[i], got.acc[i]);
        end
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni;
  logic in_valid_i, in_stall_o, kind_i;
  logic [1:0] rotor_i;
  logic signed [31:0] thrust_i, spin_i, drag_torque_i, roll_rate_i, pitch_rate_i, yaw_rate_i;
  logic signed [15:0] roll_angle_i, pitch_angle_i, yaw_angle_i;
  logic out_valid_o, out_stall_i;
  logic signed [31:0] accel_longitude_o, accel_latitude_o, accel_altitude_o;
  logic signed [31:0] accel_pitch_o, accel_roll_o, accel_yaw_o;
  logic cfg_we_i;
  logic [2:0] cfg_index_i;
  logic [30:0] cfg_data_i;

  accel_board board = new();
  bit calm = 0;
  bit hold_go = 0;
  bit hold_done = 0;
  int hold_left = 0;
  int sent = 0;

  quadrotor_accel_evaluator_unit uut (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk_i) begin
    accel_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.acc = '{accel_longitude_o, accel_latitude_o, accel_altitude_o,
                  accel_pitch_o, accel_roll_o, accel_yaw_o};
      board.check_result(got);
    end
    if (hold_go && !hold_done) begin
      hold_left <= 3000;
      hold_done <= 1;
      out_stall_i <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 10);
    end
  end

  function int any_word();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 0;
      3, 4: return int'($urandom_range(0, 1 << 22)) - (1 << 21);
      default: return $urandom;
    endcase
  endfunction

  function shortint any_angle();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd16384;
      3: return -16'sd16384;
      default: return shortint'($urandom);
    endcase
  endfunction

  function beat_t any_beat();
    beat_t b;
    b.kind = $urandom_range(99) < 60;
    b.rotor = 2'($urandom);
    b.thrust = any_word();
    b.spin = any_word();
    b.torque = any_word();
    b.roll_ang = any_angle();
    b.pitch_ang = any_angle();
    b.yaw_ang = any_angle();
    b.roll_rt = any_word();
    b.pitch_rt = any_word();
    b.yaw_rt = any_word();
    return b;
  endfunction

  task automatic send_beat(beat_t b);
    in_valid_i <= 1;
    kind_i <= b.kind;
    rotor_i <= b.rotor;
    thrust_i <= b.thrust;
    spin_i <= b.spin;
    drag_torque_i <= b.torque;
    roll_angle_i <= b.roll_ang;
    pitch_angle_i <= b.pitch_ang;
    yaw_angle_i <= b.yaw_ang;
    roll_rate_i <= b.roll_rt;
    pitch_rate_i <= b.pitch_rt;
    yaw_rate_i <= b.yaw_rt;
    do @(posedge clk_i); while (in_stall_o);
    board.note_beat(b);
    sent++;
    if (!calm && $urandom_range(99) < 10) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (board.pending_accels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(qae_pkg::cfg_reg_e idx, longint val);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val[30:0];
    @(posedge clk_i);
    cfg_we_i <= 0;
    board.set_reg(idx, val);
  endtask

  task automatic write_raw(logic [2:0] idx, logic [30:0] val);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    board.set_reg(idx, val);
  endtask

  task automatic random_run(int n);
    repeat (n) send_beat(any_beat());
  endtask

  initial begin
    beat_t b;
    shortint angs [6] = '{0, 16'sh7FFF, 16'sh8000, 16384, -16384, 16385};
    rst_ni = 0;
    in_valid_i = 0;
    kind_i = 0;
    rotor_i = 0;
    thrust_i = 0;
    spin_i = 0;
    drag_torque_i = 0;
    roll_angle_i = 0;
    pitch_angle_i = 0;
    yaw_angle_i = 0;
    roll_rate_i = 0;
    pitch_rate_i = 0;
    yaw_rate_i = 0;
    out_stall_i = 0;
    cfg_we_i = 0;
    cfg_index_i = 0;
    cfg_data_i = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: attitude extremes then each rotor at both ends and at a small value
    b = '{default: 0};
    foreach (angs[i]) begin
      b.kind = 0;
      b.roll_ang = angs[i];
      b.pitch_ang = angs[(i + 1) % 6];
      b.yaw_ang = angs[(i + 2) % 6];
      b.roll_rt = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      b.pitch_rt = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      b.yaw_rt = i * 70000 - 200000;
      send_beat(b);
    end
    for (int r = 0; r < 4; r++) begin
      b.kind = 1;
      b.rotor = 2'(r);
      b.thrust = 32'h7FFF_FFFF;
      b.spin = 32'h8000_0000;
      b.torque = 32'h7FFF_FFFF;
      send_beat(b);
      b.thrust = 32'h8000_0000;
      b.spin = 32'h7FFF_FFFF;
      b.torque = 32'h8000_0000;
      send_beat(b);
      b.thrust = 5 << 16;
      b.spin = (r + 1) << 18;
      b.torque = -(r << 12);
      send_beat(b);
    end
    random_run(280);

    // receiver holds off while the sender keeps pushing
    hold_go = 1;
    random_run(60);
    drain();

    write_reg(qae_pkg::REG_MASS, 1);
    write_reg(qae_pkg::REG_I1, 31'h7FFF_FFFF);
    write_reg(qae_pkg::REG_I2, 31'h7FFF_FFFF);
    write_reg(qae_pkg::REG_I3, 1);
    write_reg(qae_pkg::REG_JR, 31'h7FFF_FFFF);
    write_reg(qae_pkg::REG_ARM, 31'h7FFF_FFFF);
    random_run(300);
    drain();

    write_reg(qae_pkg::REG_MASS, 0);
    write_reg(qae_pkg::REG_I1, 0);
    write_reg(qae_pkg::REG_I2, 0);
    write_reg(qae_pkg::REG_I3, 0);
    write_reg(qae_pkg::REG_JR, 0);
    write_reg(qae_pkg::REG_ARM, 0);
    write_raw(3'd6, 31'h5555_5555);
    write_raw(3'd7, 31'h2AAA_AAAA);
    random_run(300);
    drain();

    // long stretch without any idling
    calm = 1;
    write_reg(qae_pkg::REG_MASS, 3 << 15);
    write_reg(qae_pkg::REG_I1, 1 << 14);
    write_reg(qae_pkg::REG_I2, 3 << 13);
    write_reg(qae_pkg::REG_I3, 1 << 15);
    write_reg(qae_pkg::REG_JR, 1 << 6);
    write_reg(qae_pkg::REG_ARM, 3 << 14);
    random_run(300);
    drain();
    calm = 0;

    repeat (2) begin
      write_reg(qae_pkg::REG_MASS, $urandom_range(1, 31'h7FFF_FFFF));
      write_reg(qae_pkg::REG_I1, $urandom_range(1, 1 << 20));
      write_reg(qae_pkg::REG_I2, $urandom_range(1, 1 << 20));
      write_reg(qae_pkg::REG_I3, $urandom_range(1, 1 << 20));
      write_reg(qae_pkg::REG_JR, $urandom & 31'h7FFF_FFFF);
      write_reg(qae_pkg::REG_ARM, $urandom_range(0, 1 << 18));
      random_run(340);
      drain();
    end

    repeat (400) @(posedge clk_i);
    $display("sent %0d input beats over six register settings, checked %0d result beats,",
             sent, board.checked);
    $display("including zero divisors, angle wrap points and a long output hold-off");
    if (board.errors == 0 && board.pending_accels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/qae_pkg.sv
rtl/qae_ctrl.sv
rtl/qae_datapath.sv
rtl/quadrotor_accel_evaluator_unit.sv
rtl/qae_checker.sv
tb/tb_top.sv
